[design/ravv_pkg.sv]
// ----------------------------------------------------------------------------
// ravv_pkg: shared types and constants for the axis-angle rotate unit
// Widths, the CORDIC arctangent table and the words carried down the pipe.
// ----------------------------------------------------------------------------
package ravv_pkg;

    localparam int CW  = 32;        // coordinate width, Q16.16
    localparam int AW  = 16;        // angle width, one turn = 2^AW
    localparam int XW  = 18;        // axis width, Q1.16
    localparam int CS  = 30;        // CORDIC iterations
    localparam int XYW = 33;        // CORDIC x/y width
    localparam int ZW  = 34;        // CORDIC residual angle width
    localparam int SCW = 19;        // cosine/sine width in Q16
    localparam int TW  = SCW + 1;   // 1 - cos
    localparam int SKW = 20;        // axis times sine, Q16
    localparam int AAW = 2 * XW;    // axis component product
    localparam int PW  = TW + AAW;  // (1 - cos) * ai * aj
    localparam int MW  = 22;        // matrix entry, Q16
    localparam int VPW = MW + CW;   // entry times coordinate
    localparam int SW  = VPW + 2;   // sum of three products
    localparam int RW  = SW - 16;   // rounded result before saturation

    localparam logic signed [XYW-1:0] CORDIC_START = XYW'(652032874);

    typedef struct packed {
        logic signed [XW-1:0] ax;
        logic signed [XW-1:0] ay;
        logic signed [XW-1:0] az;
        logic signed [CW-1:0] vx;
        logic signed [CW-1:0] vy;
        logic signed [CW-1:0] vz;
    } item_t;

    typedef struct packed {
        logic                  valid;
        logic [1:0]            quad;
        logic signed [XYW-1:0] x;
        logic signed [XYW-1:0] y;
        logic signed [ZW-1:0]  z;
        item_t                 item;
    } cordic_t;

    function automatic logic [31:0] atan_turns(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

[design/ravv_cordic_cell.sv]
// ----------------------------------------------------------------------------
// ravv_cordic_cell: one CORDIC rotation step
// Holds one word and passes it, rotated by one micro-angle, to the next cell.
// ----------------------------------------------------------------------------
module ravv_cordic_cell
    import ravv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic [4:0] step,
    input  cordic_t    d,
    output cordic_t    q
);

    logic                  valid_reg;
    cordic_t               data_reg;
    cordic_t               data_next;
    logic signed [XYW-1:0] dx;
    logic signed [XYW-1:0] dy;
    logic signed [ZW-1:0]  da;

    always_comb
    begin
        dx = d.y >>> step;
        dy = d.x >>> step;
        da = signed'({{(ZW-32){1'b0}}, atan_turns(step)});
        data_next = d;
        if (!d.z[ZW-1])
        begin
            data_next.x = d.x - dx;
            data_next.y = d.y + dy;
            data_next.z = d.z - da;
        end
        else
        begin
            data_next.x = d.x + dx;
            data_next.y = d.y - dy;
            data_next.z = d.z + da;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= d.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    always_comb
    begin
        q = data_reg;
        q.valid = valid_reg;
    end

endmodule

[design/ravv_matrix.sv]
// ----------------------------------------------------------------------------
// ravv_matrix: Rodrigues matrix build and matrix-vector product
// Six registered stages from CORDIC output to the saturated result word.
// ----------------------------------------------------------------------------
module ravv_matrix
    import ravv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  cordic_t              d,
    output logic                 valid,
    output logic signed [CW-1:0] rx,
    output logic signed [CW-1:0] ry,
    output logic signed [CW-1:0] rz,
    output logic                 clip
);

    localparam logic signed [RW-1:0] TOP = {{(RW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [RW-1:0] BOT = ~TOP;

    logic [4:0] vld_reg;
    logic       out_vld_reg;

    // Stage A: quadrant fold and rounding to Q16.
    logic signed [XYW-1:0] cx, sy;
    logic signed [XYW-1:0] c_full, s_full;
    logic signed [SCW-1:0] c_a_reg, s_a_reg;
    item_t                 it_a_reg;

    // Stage B
    logic signed [TW-1:0]  t_b_reg;
    logic signed [SCW-1:0] c_b_reg;
    logic signed [SKW-1:0] sk_b_reg [3];
    logic signed [AAW-1:0] aa_b_reg [9];
    logic signed [XW-1:0]  axv [3];
    logic signed [XW+SCW-1:0] sprod [3];
    item_t                 it_b_reg;

    // Stage C
    logic signed [PW-1:0]  p_c_reg [9];
    logic signed [SCW-1:0] c_c_reg;
    logic signed [SKW-1:0] sk_c_reg [3];
    item_t                 it_c_reg;

    // Stage D
    logic signed [MW-1:0]  m_next [9];
    logic signed [MW-1:0]  m_d_reg [9];
    item_t                 it_d_reg;

    // Stage E
    logic signed [VPW-1:0] pr_e_reg [9];
    logic signed [CW-1:0]  vv [3];

    // Stage F
    logic signed [SW-1:0]  sum [3];
    logic signed [RW-1:0]  rr [3];
    logic signed [CW-1:0]  sat [3];
    logic [2:0]            hit;
    logic signed [CW-1:0]  r_reg [3];
    logic                  clip_reg;

    always_comb
    begin
        case (d.quad)
            2'd0:    begin cx = d.x;  sy = d.y;  end
            2'd1:    begin cx = -d.y; sy = d.x;  end
            2'd2:    begin cx = -d.x; sy = -d.y; end
            default: begin cx = d.y;  sy = -d.x; end
        endcase
        c_full = (cx + XYW'(1 << 13)) >>> 14;
        s_full = (sy + XYW'(1 << 13)) >>> 14;
    end

    assign axv[0] = it_a_reg.ax;
    assign axv[1] = it_a_reg.ay;
    assign axv[2] = it_a_reg.az;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sprod[i] = axv[i] * s_a_reg;
    end

    // The skew part enters with the sign of the cross-product matrix.
    always_comb
    begin
        for (int k = 0; k < 9; k++)
            m_next[k] = MW'((p_c_reg[k] + PW'(64'sd1 << 31)) >>> 32);
        m_next[0] = m_next[0] + MW'(c_c_reg);
        m_next[4] = m_next[4] + MW'(c_c_reg);
        m_next[8] = m_next[8] + MW'(c_c_reg);
        m_next[1] = m_next[1] - MW'(sk_c_reg[2]);
        m_next[3] = m_next[3] + MW'(sk_c_reg[2]);
        m_next[2] = m_next[2] + MW'(sk_c_reg[1]);
        m_next[6] = m_next[6] - MW'(sk_c_reg[1]);
        m_next[5] = m_next[5] - MW'(sk_c_reg[0]);
        m_next[7] = m_next[7] + MW'(sk_c_reg[0]);
    end

    assign vv[0] = it_d_reg.vx;
    assign vv[1] = it_d_reg.vy;
    assign vv[2] = it_d_reg.vz;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum[i] = SW'(pr_e_reg[3*i]) + SW'(pr_e_reg[3*i+1]) + SW'(pr_e_reg[3*i+2]);
            rr[i]  = RW'((sum[i] + SW'(1 << 15)) >>> 16);
            hit[i] = (rr[i] > TOP) || (rr[i] < BOT);
            if (rr[i] > TOP)
                sat[i] = TOP[CW-1:0];
            else if (rr[i] < BOT)
                sat[i] = BOT[CW-1:0];
            else
                sat[i] = rr[i][CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[3:0], d.valid};
            out_vld_reg <= vld_reg[4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_a_reg  <= SCW'(c_full);
            s_a_reg  <= SCW'(s_full);
            it_a_reg <= d.item;

            t_b_reg  <= TW'(65536) - TW'(c_a_reg);
            c_b_reg  <= c_a_reg;
            it_b_reg <= it_a_reg;
            for (int i = 0; i < 3; i++)
            begin
                sk_b_reg[i] <= SKW'((sprod[i] + (XW+SCW)'(1 << 15)) >>> 16);
                for (int j = 0; j < 3; j++)
                    aa_b_reg[3*i+j] <= axv[i] * axv[j];
            end

            for (int k = 0; k < 9; k++)
                p_c_reg[k] <= t_b_reg * aa_b_reg[k];
            c_c_reg  <= c_b_reg;
            sk_c_reg <= sk_b_reg;
            it_c_reg <= it_b_reg;

            m_d_reg  <= m_next;
            it_d_reg <= it_c_reg;

            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    pr_e_reg[3*i+j] <= m_d_reg[3*i+j] * vv[j];

            r_reg    <= sat;
            clip_reg <= |hit;
        end
    end

    assign valid = out_vld_reg;
    assign rx    = r_reg[0];
    assign ry    = r_reg[1];
    assign rz    = r_reg[2];
    assign clip  = clip_reg;

endmodule

[design/axis_angle_vector_rotate_unit.sv]
// ----------------------------------------------------------------------------
// axis_angle_vector_rotate_unit: rotate a vector about an axis by an angle
// CORDIC cell chain for cosine/sine, then the Rodrigues matrix product.
// ----------------------------------------------------------------------------
//  channel | handshake             | words
//  in      | in_valid / in_ready   | axis_x/y/z, turn_angle, vec_x/y/z
//  out     | out_valid / out_ready | out_x/y/z, clipped
//
// One word is accepted per cycle unless the pipe holds; the path runs through 30 CORDIC
// cells, then six matrix stages including the output register.
// The whole pipe advances together; it holds only while the output word
// waits and out_ready is low.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotate_unit
    import ravv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [XW-1:0] axis_x,
    input  logic signed [XW-1:0] axis_y,
    input  logic signed [XW-1:0] axis_z,
    input  logic [AW-1:0]        turn_angle,
    input  logic signed [CW-1:0] vec_x,
    input  logic signed [CW-1:0] vec_y,
    input  logic signed [CW-1:0] vec_z,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [CW-1:0] out_x,
    output logic signed [CW-1:0] out_y,
    output logic signed [CW-1:0] out_z,
    output logic                 clipped
);

    logic    en;
    cordic_t chain [CS+1];

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    always_comb
    begin
        chain[0].valid   = in_valid;
        chain[0].quad    = turn_angle[AW-1:AW-2];
        chain[0].x       = CORDIC_START;
        chain[0].y       = '0;
        chain[0].z       = ZW'(turn_angle[AW-3:0]) << (32 - AW);
        chain[0].item.ax = axis_x;
        chain[0].item.ay = axis_y;
        chain[0].item.az = axis_z;
        chain[0].item.vx = vec_x;
        chain[0].item.vy = vec_y;
        chain[0].item.vz = vec_z;
    end

    for (genvar g = 0; g < CS; g++)
    begin : g_cell
        ravv_cordic_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .step  (5'(g)),
            .d     (chain[g]),
            .q     (chain[g+1])
        );
    end

    ravv_matrix u_matrix (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d     (chain[CS]),
        .valid (out_valid),
        .rx    (out_x),
        .ry    (out_y),
        .rz    (out_z),
        .clip  (clipped)
    );

`ifndef ASSERT_OFF
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = ~CMAX;

    a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |-> (out_x == CMAX || out_x == CMIN || out_y == CMAX ||
                                  out_y == CMIN || out_z == CMAX || out_z == CMIN))
        else $error("clipped set without a saturated component");

    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output stall");

    a_last_cell_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !chain[CS].valid && en |=> !chain[CS].valid || $past(chain[CS-1].valid))
        else $error("cordic chain produced a word from nothing");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> chain[CS].valid == $past(chain[CS].valid))
        else $error("cordic chain moved during a stall");
`endif

endmodule
